[design/can_bts_pkg.sv]
// shared types, constants and the segment table of the can bit timing search
package can_bts_pkg;

   // field widths
   localparam int CLK_W    = 27;
   localparam int BAUD_W   = 20;
   localparam int DIVR_W   = 4;
   localparam int TIME_W   = 15;
   localparam int NT_W     = 5;
   localparam int DSEL_W   = 5;
   localparam int BRP_W    = 11;
   localparam int PRESC_W  = 7;
   localparam int CNT_W    = $clog2(CLK_W);
   localparam int ADDR_W   = 3;
   localparam int DATA_W   = 32;

   // search limits
   localparam logic [NT_W-1:0]   NT_MAX    = 5'd24;
   localparam logic [NT_W-1:0]   NT_MIN    = 5'd4;
   localparam logic [NT_W-1:0]   NT_STEP   = 5'd2;
   localparam logic [DSEL_W-1:0] DIV_FIRST = 5'd1;
   localparam logic [DSEL_W-1:0] DIV_MAX   = 5'd16;
   localparam logic [CLK_W-1:0]  PRESC_MAX = 27'd64;
   // prescaler above 16 * 64 can never be split by any divider
   localparam logic [CLK_W-1:0]  BRP_LIMIT = 27'd1024;

   // reset values
   localparam logic [CLK_W-1:0]  RESET_CLK    = 27'd48000000;
   localparam logic [DIVR_W-1:0] RESET_DIV    = 4'd7;
   localparam logic [TIME_W-1:0] RESET_TIMING = 15'd32305;

   // register index of the clock frequency
   localparam logic REG_CLOCK_HZ = 1'b0;

   // divider request from the sequencer
   typedef struct packed {
      logic              start;
      logic [CLK_W-1:0]  dividend;
      logic [BAUD_W-1:0] divisor;
   } div_req_type;

   // divider answer, held until the next start
   typedef struct packed {
      logic              done;
      logic [CLK_W-1:0]  quotient;
      logic [BAUD_W-1:0] remainder;
   } div_rsp_type;

   // phase segments for a nominal bit time: {seg2[2:0], seg1[3:0]}
   function automatic logic [6:0] seg_fields(input logic [NT_W-1:0] nt);
      logic [6:0] segs;
      begin
         unique case (nt)
            5'd24:   segs = {3'd7, 4'd14};
            5'd22:   segs = {3'd6, 4'd13};
            5'd20:   segs = {3'd5, 4'd12};
            5'd18:   segs = {3'd5, 4'd10};
            5'd16:   segs = {3'd4, 4'd9};
            5'd14:   segs = {3'd3, 4'd8};
            5'd12:   segs = {3'd3, 4'd6};
            5'd10:   segs = {3'd2, 4'd5};
            5'd8:    segs = {3'd1, 4'd4};
            5'd6:    segs = {3'd1, 4'd2};
            5'd4:    segs = {3'd0, 4'd1};
            default: segs = 7'd0;
         endcase
         seg_fields = segs;
      end
   endfunction

endpackage

[design/can_bts_div.sv]
// bit-serial restoring divider shared by all steps of the search
module can_bts_div (
   input  logic                      clock,
   input  logic                      reset,
   input  can_bts_pkg::div_req_type  div_req,
   output can_bts_pkg::div_rsp_type  div_rsp
);

   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;
   logic [can_bts_pkg::CNT_W-1:0]   count_ff, count_in;
   logic [can_bts_pkg::CLK_W-1:0]   dvd_ff, dvd_in;
   logic [can_bts_pkg::BAUD_W-1:0]  rem_ff, rem_in;
   logic [can_bts_pkg::BAUD_W-1:0]  dvs_ff, dvs_in;
   logic [can_bts_pkg::BAUD_W:0]    trial;
   logic [can_bts_pkg::BAUD_W:0]    diff;
   logic                            take;

   // one quotient bit per cycle
   assign trial = {rem_ff, dvd_ff[can_bts_pkg::CLK_W-1]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign take  = (trial >= {1'b0, dvs_ff});

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      dvd_in   = dvd_ff;
      rem_in   = rem_ff;
      dvs_in   = dvs_ff;
      if (div_req.start) begin
         busy_in  = 1'b1;
         count_in = can_bts_pkg::CNT_W'(can_bts_pkg::CLK_W - 1);
         dvd_in   = div_req.dividend;
         rem_in   = '0;
         dvs_in   = div_req.divisor;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[can_bts_pkg::CLK_W-2:0], take};
         rem_in = take ? diff[can_bts_pkg::BAUD_W-1:0] : trial[can_bts_pkg::BAUD_W-1:0];
         if (count_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            count_in = count_ff - 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // datapath shift registers
   always_ff @(posedge clock) begin
      count_ff <= count_in;
      dvd_ff   <= dvd_in;
      rem_ff   <= rem_in;
      dvs_ff   <= dvs_in;
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = dvd_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

[design/can_bts_ctrl.sv]
// search sequencer: walks nominal bit times and clock dividers, holds the result
module can_bts_ctrl (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [can_bts_pkg::CLK_W-1:0]       clock_hz,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [can_bts_pkg::BAUD_W-1:0]      req_baud_rate,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_found,
   output logic [can_bts_pkg::DIVR_W-1:0]      rsp_clock_divider,
   output logic [can_bts_pkg::TIME_W-1:0]      rsp_timing_word,
   output can_bts_pkg::div_req_type            div_req,
   input  can_bts_pkg::div_rsp_type            div_rsp
);

   typedef enum logic [4:0] {
      ST_IDLE    = 5'b00001,
      ST_QUANTA  = 5'b00010,
      ST_NOMINAL = 5'b00100,
      ST_DIVIDER = 5'b01000,
      ST_REPORT  = 5'b10000
   } state_type;

   state_type                         state_ff, state_in;
   logic [can_bts_pkg::NT_W-1:0]      nt_ff, nt_in;
   logic [can_bts_pkg::DSEL_W-1:0]    d_ff, d_in;
   logic [can_bts_pkg::CLK_W-1:0]     quanta_ff, quanta_in;
   logic [can_bts_pkg::BRP_W-1:0]     brp_ff, brp_in;
   logic                              found_ff, found_in;
   logic [can_bts_pkg::DIVR_W-1:0]    held_div_ff, held_div_in;
   logic [can_bts_pkg::TIME_W-1:0]    held_timing_ff, held_timing_in;
   logic [can_bts_pkg::NT_W-1:0]      nt_next;
   logic [can_bts_pkg::DSEL_W-1:0]    d_next;
   logic [can_bts_pkg::DSEL_W-1:0]    d_minus;
   logic [can_bts_pkg::PRESC_W-1:0]   presc_minus;
   logic [6:0]                        segs;

   assign nt_next     = nt_ff - can_bts_pkg::NT_STEP;
   assign d_next      = d_ff + 1'b1;
   assign d_minus     = d_ff - 1'b1;
   assign presc_minus = div_rsp.quotient[can_bts_pkg::PRESC_W-1:0] - 1'b1;
   assign segs        = can_bts_pkg::seg_fields(nt_ff);

   // search sequencer
   always_comb begin
      state_in         = state_ff;
      nt_in            = nt_ff;
      d_in             = d_ff;
      quanta_in        = quanta_ff;
      brp_in           = brp_ff;
      found_in         = found_ff;
      held_div_in      = held_div_ff;
      held_timing_in   = held_timing_ff;
      div_req.start    = 1'b0;
      div_req.dividend = quanta_ff;
      div_req.divisor  = {{(can_bts_pkg::BAUD_W - can_bts_pkg::NT_W){1'b0}}, nt_ff};
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_baud_rate == '0) begin
                  found_in = 1'b0;
                  state_in = ST_REPORT;
               end else begin
                  div_req.start    = 1'b1;
                  div_req.dividend = clock_hz;
                  div_req.divisor  = req_baud_rate;
                  state_in         = ST_QUANTA;
               end
            end
         end
         ST_QUANTA: begin
            if (div_rsp.done) begin
               if (div_rsp.quotient == '0) begin
                  found_in = 1'b0;
                  state_in = ST_REPORT;
               end else begin
                  quanta_in        = div_rsp.quotient;
                  nt_in            = can_bts_pkg::NT_MAX;
                  div_req.start    = 1'b1;
                  div_req.dividend = div_rsp.quotient;
                  div_req.divisor  = {{(can_bts_pkg::BAUD_W - can_bts_pkg::NT_W){1'b0}},
                                      can_bts_pkg::NT_MAX};
                  state_in         = ST_NOMINAL;
               end
            end
         end
         ST_NOMINAL: begin
            if (div_rsp.done) begin
               if (div_rsp.remainder == '0 && div_rsp.quotient <= can_bts_pkg::BRP_LIMIT) begin
                  // nominal time fits, start the divider sweep
                  brp_in           = div_rsp.quotient[can_bts_pkg::BRP_W-1:0];
                  d_in             = can_bts_pkg::DIV_FIRST;
                  div_req.start    = 1'b1;
                  div_req.dividend = div_rsp.quotient;
                  div_req.divisor  = {{(can_bts_pkg::BAUD_W - can_bts_pkg::DSEL_W){1'b0}},
                                      can_bts_pkg::DIV_FIRST};
                  state_in         = ST_DIVIDER;
               end else if (nt_ff == can_bts_pkg::NT_MIN) begin
                  found_in = 1'b0;
                  state_in = ST_REPORT;
               end else begin
                  nt_in            = nt_next;
                  div_req.start    = 1'b1;
                  div_req.dividend = quanta_ff;
                  div_req.divisor  = {{(can_bts_pkg::BAUD_W - can_bts_pkg::NT_W){1'b0}}, nt_next};
               end
            end
         end
         ST_DIVIDER: begin
            if (div_rsp.done) begin
               if (div_rsp.remainder == '0 && div_rsp.quotient <= can_bts_pkg::PRESC_MAX) begin
                  // hit: store divider and packed timing word
                  found_in       = 1'b1;
                  held_div_in    = d_minus[can_bts_pkg::DIVR_W-1:0];
                  held_timing_in = {segs, 2'b00, presc_minus[5:0]};
                  state_in       = ST_REPORT;
               end else if (d_ff != can_bts_pkg::DIV_MAX) begin
                  d_in             = d_next;
                  div_req.start    = 1'b1;
                  div_req.dividend = {{(can_bts_pkg::CLK_W - can_bts_pkg::BRP_W){1'b0}}, brp_ff};
                  div_req.divisor  = {{(can_bts_pkg::BAUD_W - can_bts_pkg::DSEL_W){1'b0}}, d_next};
               end else if (nt_ff == can_bts_pkg::NT_MIN) begin
                  found_in = 1'b0;
                  state_in = ST_REPORT;
               end else begin
                  nt_in            = nt_next;
                  div_req.start    = 1'b1;
                  div_req.dividend = quanta_ff;
                  div_req.divisor  = {{(can_bts_pkg::BAUD_W - can_bts_pkg::NT_W){1'b0}}, nt_next};
                  state_in         = ST_NOMINAL;
               end
            end
         end
         ST_REPORT: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control and held state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         found_ff       <= 1'b0;
         held_div_ff    <= can_bts_pkg::RESET_DIV;
         held_timing_ff <= can_bts_pkg::RESET_TIMING;
      end else begin
         state_ff       <= state_in;
         found_ff       <= found_in;
         held_div_ff    <= held_div_in;
         held_timing_ff <= held_timing_in;
      end
   end

   // search working registers
   always_ff @(posedge clock) begin
      nt_ff     <= nt_in;
      d_ff      <= d_in;
      quanta_ff <= quanta_in;
      brp_ff    <= brp_in;
   end

   assign req_ready         = (state_ff == ST_IDLE);
   assign rsp_valid         = (state_ff == ST_REPORT);
   assign rsp_found         = found_ff;
   assign rsp_clock_divider = held_div_ff;
   assign rsp_timing_word   = held_timing_ff;

endmodule

[design/can_bit_timing_search.sv]
// top level of the can bit timing search: register port, sequencer and divider
//
// Takes a requested bit rate and finds a CAN bit timing for the programmed
// peripheral clock (csr register 0, byte address 0, reset 48 MHz). One item is
// worked on at a time; a new request is taken once the previous result transfer
// is done. All arithmetic runs through one bit-serial divider: one division for
// clock / bit rate, one for each nominal bit time tried (24 down to 4), and up
// to sixteen more for the clock divider sweep of a nominal time whose prescaler
// is at most 1024. A zero bit rate goes to the report without any division. On a
// miss the result reports found = 0 with the previously stored divider and
// timing word.
module can_bit_timing_search (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [can_bts_pkg::BAUD_W-1:0]      req_baud_rate,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_found,
   output logic [can_bts_pkg::DIVR_W-1:0]      rsp_clock_divider,
   output logic [can_bts_pkg::TIME_W-1:0]      rsp_timing_word,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [can_bts_pkg::ADDR_W-1:0]      csr_paddr,
   input  logic [can_bts_pkg::DATA_W-1:0]      csr_pwdata,
   output logic [can_bts_pkg::DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready
);

   logic [can_bts_pkg::CLK_W-1:0]  clock_hz_ff, clock_hz_in;
   logic                           csr_write;
   logic                           csr_hit;
   can_bts_pkg::div_req_type       div_req;
   can_bts_pkg::div_rsp_type       div_rsp;

   // register port decode
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_hit    = (csr_paddr[2] == can_bts_pkg::REG_CLOCK_HZ);

   always_comb begin
      clock_hz_in = clock_hz_ff;
      if (csr_write && csr_hit) begin
         clock_hz_in = csr_pwdata[can_bts_pkg::CLK_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clock_hz_ff <= can_bts_pkg::RESET_CLK;
      end else begin
         clock_hz_ff <= clock_hz_in;
      end
   end

   // read back
   assign csr_prdata = csr_hit ?
      {{(can_bts_pkg::DATA_W - can_bts_pkg::CLK_W){1'b0}}, clock_hz_ff} : '0;

   can_bts_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .clock_hz          (clock_hz_ff),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_baud_rate     (req_baud_rate),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_found         (rsp_found),
      .rsp_clock_divider (rsp_clock_divider),
      .rsp_timing_word   (rsp_timing_word),
      .div_req           (div_req),
      .div_rsp           (div_rsp)
   );

   can_bts_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

endmodule

[tb/tb_can_bit_timing_search.sv]
// self-checking testbench for the can bit timing search: directed table, then random rates
module tb_can_bit_timing_search;

   localparam int BAUD_W = can_bts_pkg::BAUD_W;
   localparam int CLK_W  = can_bts_pkg::CLK_W;
   localparam int DIVR_W = can_bts_pkg::DIVR_W;
   localparam int TIME_W = can_bts_pkg::TIME_W;
   localparam int ADDR_W = can_bts_pkg::ADDR_W;
   localparam int DATA_W = can_bts_pkg::DATA_W;

   // register map: clock frequency at index 0, the next word is unmapped
   localparam logic [ADDR_W-1:0] ADDR_CLOCK_HZ = ADDR_W'(4 * can_bts_pkg::REG_CLOCK_HZ);
   localparam logic [ADDR_W-1:0] ADDR_UNMAPPED = ADDR_W'(4);

   // search limits of the timing calculation
   localparam int NOMINAL_TOP    = 24;
   localparam int NOMINAL_BOTTOM = 4;
   localparam int DIVIDER_TOP    = 16;
   localparam int PRESCALER_TOP  = 64;

   localparam logic [BAUD_W-1:0] RATE_MAX  = {BAUD_W{1'b1}};
   localparam logic [CLK_W-1:0]  CLOCK_MAX = {CLK_W{1'b1}};

   localparam int RANDOM_PHASES   = 6;
   localparam int RATES_PER_PHASE = 100;
   localparam int DRAIN_CYCLES    = 6000;
   localparam int CYCLE_LIMIT     = 20_000_000;
   localparam int REPORT_LIMIT    = 10;

   typedef struct packed {
      logic              found;
      logic [DIVR_W-1:0] divider;
      logic [TIME_W-1:0] timing;
   } timing_result_type;

   typedef struct packed {
      bit                set_clock;
      logic [ADDR_W-1:0] addr;
      logic [DATA_W-1:0] wdata;
      logic [BAUD_W-1:0] baud;
      bit                typed;
      timing_result_type result;
   } vector_row_type;

   localparam timing_result_type UNTYPED       = '0;
   localparam timing_result_type HELD_AT_RESET =
      '{1'b0, can_bts_pkg::RESET_DIV, can_bts_pkg::RESET_TIMING};
   // 24 quanta per bit at prescaler 1: seg2 7, seg1 14
   localparam timing_result_type ONE_QUANTUM_24 = '{1'b1, 4'd0, 15'd32256};

   localparam int NUM_ROWS = 22;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [BAUD_W-1:0]   req_baud_rate = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic                rsp_found;
   logic [DIVR_W-1:0]   rsp_clock_divider;
   logic [TIME_W-1:0]   rsp_timing_word;
   logic                csr_psel = 1'b0;
   logic                csr_penable = 1'b0;
   logic                csr_pwrite = 1'b0;
   logic [ADDR_W-1:0]   csr_paddr = '0;
   logic [DATA_W-1:0]   csr_pwdata = '0;
   logic [DATA_W-1:0]   csr_prdata;
   logic                csr_pready;

   // predictor state
   logic [CLK_W-1:0]    clock_setting = can_bts_pkg::RESET_CLK;
   logic [DIVR_W-1:0]   held_divider = can_bts_pkg::RESET_DIV;
   logic [TIME_W-1:0]   held_timing = can_bts_pkg::RESET_TIMING;
   timing_result_type   pending_timings [$];

   int                  mismatch_count = 0;
   int                  cycle_count = 0;
   int                  send_idle_pct = 0;
   int                  recv_idle_pct = 0;

   // directed rows: extremes, standard rates, zero rate and zero quotient cases
   vector_row_type directed_rows [NUM_ROWS] = '{
      '{1'b0, ADDR_CLOCK_HZ, 32'd0,        20'd0,       1'b1, HELD_AT_RESET},
      '{1'b0, ADDR_CLOCK_HZ, 32'd0,        20'd1,       1'b1, HELD_AT_RESET},
      '{1'b0, ADDR_CLOCK_HZ, 32'd0,        RATE_MAX,    1'b1, HELD_AT_RESET},
      '{1'b0, ADDR_CLOCK_HZ, 32'd0,        20'd1000000, 1'b0, UNTYPED},
      '{1'b0, ADDR_CLOCK_HZ, 32'd0,        20'd500000,  1'b0, UNTYPED},
      '{1'b0, ADDR_CLOCK_HZ, 32'd0,        20'd250000,  1'b0, UNTYPED},
      '{1'b0, ADDR_CLOCK_HZ, 32'd0,        20'd125000,  1'b0, UNTYPED},
      '{1'b0, ADDR_CLOCK_HZ, 32'd0,        20'd0,       1'b0, UNTYPED},
      '{1'b0, ADDR_CLOCK_HZ, 32'd0,        20'd83333,   1'b0, UNTYPED},
      '{1'b0, ADDR_CLOCK_HZ, 32'd0,        20'd20000,   1'b0, UNTYPED},
      '{1'b0, ADDR_CLOCK_HZ, 32'd0,        20'hAAAAA,   1'b0, UNTYPED},
      '{1'b0, ADDR_CLOCK_HZ, 32'd0,        20'h55555,   1'b0, UNTYPED},
      '{1'b1, ADDR_CLOCK_HZ, 32'd1,        20'd1,       1'b0, UNTYPED},
      '{1'b0, ADDR_CLOCK_HZ, 32'd0,        20'd2,       1'b0, UNTYPED},
      '{1'b1, ADDR_CLOCK_HZ, 32'd0,        20'd1000,    1'b0, UNTYPED},
      '{1'b1, ADDR_CLOCK_HZ, 32'd24,       20'd1,       1'b1, ONE_QUANTUM_24},
      '{1'b1, ADDR_CLOCK_HZ, 32'd100000000, 20'd1000000, 1'b0, UNTYPED},
      '{1'b0, ADDR_CLOCK_HZ, 32'd0,        20'd1,       1'b0, UNTYPED},
      '{1'b1, ADDR_CLOCK_HZ, 32'(CLOCK_MAX), 20'd1,     1'b0, UNTYPED},
      '{1'b0, ADDR_CLOCK_HZ, 32'd0,        RATE_MAX,    1'b0, UNTYPED},
      '{1'b1, ADDR_UNMAPPED, 32'hFFFFFFFF, 20'd1000000, 1'b0, UNTYPED},
      '{1'b1, ADDR_CLOCK_HZ, 32'd48000000, 20'h80000,   1'b0, UNTYPED}
   };

   can_bit_timing_search uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_baud_rate     (req_baud_rate),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_found         (rsp_found),
      .rsp_clock_divider (rsp_clock_divider),
      .rsp_timing_word   (rsp_timing_word),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
         $display("mismatch: %s", what);
   endtask

   // first nominal bit time and clock divider that fit the quanta per bit
   function automatic timing_result_type search_bit_timing(input logic [CLK_W-1:0] clk,
                                                           input logic [BAUD_W-1:0] baud);
      int unsigned quanta, brp, presc, seg1, seg2;
      timing_result_type hit;
      hit = '0;
      if (baud != 0) begin
         quanta = clk / baud;
         if (quanta != 0) begin
            for (int nom = NOMINAL_TOP; nom >= NOMINAL_BOTTOM && !hit.found; nom -= 2) begin
               if (quanta % nom == 0) begin
                  brp  = quanta / nom;
                  seg2 = nom / 3 - 1;
                  seg1 = nom - seg2 - 3;
                  for (int dv = 1; dv <= DIVIDER_TOP && !hit.found; dv++) begin
                     presc = brp / dv;
                     if (brp % dv == 0 && presc <= PRESCALER_TOP && presc >= 1) begin
                        hit.found   = 1'b1;
                        hit.divider = DIVR_W'(dv - 1);
                        hit.timing  = {seg2[2:0], seg1[3:0], 2'b00, 6'(presc - 1)};
                     end
                  end
               end
            end
         end
      end
      return hit;
   endfunction

   // result of one request, updating the held divider and timing word
   function automatic timing_result_type predict_timing(input logic [BAUD_W-1:0] baud);
      timing_result_type hit;
      hit = search_bit_timing(clock_setting, baud);
      if (hit.found) begin
         held_divider = hit.divider;
         held_timing  = hit.timing;
      end
      return '{hit.found, held_divider, held_timing};
   endfunction

   // bit rate mix: mostly rates that give a well-formed quanta count for the clock
   function automatic logic [BAUD_W-1:0] pick_rate(input logic [CLK_W-1:0] clk);
      int unsigned pick, quanta, rate;
      int unsigned common_rates [9] = '{10000, 20000, 50000, 100000, 125000,
                                        250000, 500000, 800000, 1000000};
      pick = $urandom_range(99);
      if (pick < 60) begin
         quanta = (NOMINAL_BOTTOM + 2 * $urandom_range(10)) *
                  $urandom_range(1, PRESCALER_TOP) * $urandom_range(1, DIVIDER_TOP);
         rate = clk / quanta;
         if (rate == 0 || rate > RATE_MAX)
            rate = $urandom_range(1, RATE_MAX);
      end else if (pick < 75) begin
         rate = common_rates[$urandom_range(8)];
      end else if (pick < 80) begin
         case ($urandom_range(2))
            0:       rate = 0;
            1:       rate = 1;
            default: rate = RATE_MAX;
         endcase
      end else if (pick < 90) begin
         rate = $urandom_range(1, 2000);
      end else begin
         rate = $urandom_range(RATE_MAX);
      end
      return rate[BAUD_W-1:0];
   endfunction

   // one request transfer, with a random idle gap ahead of it
   task automatic send_rate(input logic [BAUD_W-1:0] baud, input bit typed,
                            input timing_result_type typed_result);
      timing_result_type predicted;
      predicted = predict_timing(baud);
      pending_timings.push_back(typed ? typed_result : predicted);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct)
            @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_baud_rate <= baud;
      do @(posedge clock); while (!req_ready);
   endtask

   // stop sending and wait for every outstanding result
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_timings.size() != 0)
         @(posedge clock);
   endtask

   task automatic csr_access(input logic write, input logic [ADDR_W-1:0] addr,
                             input logic [DATA_W-1:0] wdata, output logic [DATA_W-1:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= addr;
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // register write, then read back of the clock frequency
   task automatic set_clock(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] value);
      logic [DATA_W-1:0] readback;
      csr_access(1'b1, addr, value, readback);
      if (addr == ADDR_CLOCK_HZ)
         clock_setting = value[CLK_W-1:0];
      // bus idle between the write and the read
      @(posedge clock);
      csr_access(1'b0, ADDR_CLOCK_HZ, '0, readback);
      if (readback !== DATA_W'(clock_setting))
         report_mismatch($sformatf("clock_hz read expected %0d got %0d",
                                   clock_setting, readback));
   endtask

   // result transfers checked against the oldest expectation
   always @(posedge clock) begin
      timing_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_timings.size() == 0) begin
            report_mismatch($sformatf("result with nothing expected: found %0b div %0d tw %0d",
                                      rsp_found, rsp_clock_divider, rsp_timing_word));
         end else begin
            want = pending_timings.pop_front();
            if (rsp_found !== want.found || rsp_clock_divider !== want.divider ||
                rsp_timing_word !== want.timing)
               report_mismatch($sformatf(
                  "expected found %0b div %0d tw %0d, got found %0b div %0d tw %0d",
                  want.found, want.divider, want.timing,
                  rsp_found, rsp_clock_divider, rsp_timing_word));
         end
      end
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // stimulus
   initial begin
      logic [CLK_W-1:0] phase_clock;
      logic [CLK_W-1:0] phase_clocks [RANDOM_PHASES];
      phase_clocks = '{27'd100000000, CLOCK_MAX, 27'd16000000, 27'd24000,
                       27'd40000000, 27'd48000000};
      send_idle_pct = 21;
      recv_idle_pct = 72;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset value of the clock register
      set_clock(ADDR_UNMAPPED, '0);

      // directed table
      foreach (directed_rows[i]) begin
         if (directed_rows[i].set_clock) begin
            wait_idle();
            set_clock(directed_rows[i].addr, directed_rows[i].wdata);
         end
         send_rate(directed_rows[i].baud, directed_rows[i].typed, directed_rows[i].result);
      end

      // random phases: idle mix shifts from receiver-bound to sender-bound to none
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase / 2)
            0: begin
               send_idle_pct = 21;
               recv_idle_pct = 72;
            end
            1: begin
               send_idle_pct = 72;
               recv_idle_pct = 21;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         phase_clock = phase_clocks[phase];
         if (phase == 2)
            phase_clock = CLK_W'($urandom_range(1, 100000000));
         wait_idle();
         set_clock(ADDR_CLOCK_HZ, DATA_W'(phase_clock));
         repeat (RATES_PER_PHASE)
            send_rate(pick_rate(clock_setting), 1'b0, UNTYPED);
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_timings.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
